// ----- rtl/dfd_pkg.sv -----
// shared constants, types and helpers of the datagram field deframer
package dfd_pkg;

    localparam int REQ_ID_BYTES = 68;
    localparam int CNT_W        = 7;
    localparam int PHASE_W      = 4;
    localparam int CODE_W       = 3;
    localparam int VALUE_W      = 64;
    localparam int LEN_W        = 32;
    localparam int BYTE_W       = 8;

    localparam logic [PHASE_W-1:0] PH_START  = 4'd0;
    localparam logic [PHASE_W-1:0] PH_TYPE   = 4'd1;
    localparam logic [PHASE_W-1:0] PH_TERM   = 4'd2;
    localparam logic [PHASE_W-1:0] PH_REQ    = 4'd3;
    localparam logic [PHASE_W-1:0] PH_TIME   = 4'd4;
    localparam logic [PHASE_W-1:0] PH_LEN    = 4'd5;
    localparam logic [PHASE_W-1:0] PH_PREFIX = 4'd6;
    localparam logic [PHASE_W-1:0] PH_BODY   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_END    = 4'd8;

    localparam logic [CODE_W-1:0] FC_START = 3'd0;
    localparam logic [CODE_W-1:0] FC_TYPE  = 3'd1;
    localparam logic [CODE_W-1:0] FC_TERM  = 3'd2;
    localparam logic [CODE_W-1:0] FC_REQ   = 3'd3;
    localparam logic [CODE_W-1:0] FC_TIME  = 3'd4;
    localparam logic [CODE_W-1:0] FC_LEN   = 3'd5;
    localparam logic [CODE_W-1:0] FC_BODY  = 3'd6;
    localparam logic [CODE_W-1:0] FC_END   = 3'd7;

    typedef struct packed {
        logic               valid;
        logic [CODE_W-1:0]  code;
        logic [VALUE_W-1:0] value;
        logic               done;
    } t_result;

    function automatic logic [CNT_W-1:0] scalar_bytes(input logic [PHASE_W-1:0] phase);
        logic [CNT_W-1:0] n;
        unique case (phase)
            PH_TYPE:             n = 7'd1;
            PH_TERM, PH_TIME:    n = 7'd8;
            PH_LEN, PH_PREFIX:   n = 7'd4;
            default:             n = 7'd2;
        endcase
        return n;
    endfunction

endpackage

// ----- rtl/datagram_field_deframer.sv -----
// top level of the datagram field deframer
//
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_ready   | i_data_byte, i_abort_frame
//  out     | output    | o_out_valid / i_out_ready | o_field_code, o_field_value, o_frame_done
//
// one byte accepted per cycle unless the output stalls; its result is output the next cycle
// the per-byte path is a phase/count update and a 64-bit shift into the accumulator
// reset (synchronous, active low) returns to the start mark with counters cleared
// a stalled output holds; input is taken while the result register is empty or draining
module datagram_field_deframer
    import dfd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [BYTE_W-1:0]  i_data_byte,
    input  logic               i_abort_frame,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [CODE_W-1:0]  o_field_code,
    output logic [VALUE_W-1:0] o_field_value,
    output logic               o_frame_done
);

    logic    take;
    t_result result;

    assign take = i_in_valid && o_in_ready;

    dfd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_data_byte   (i_data_byte),
        .i_abort_frame (i_abort_frame),
        .o_result      (result)
    );

    dfd_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take),
        .i_result (result),
        .i_ready  (i_out_ready),
        .o_free   (o_in_ready),
        .o_valid  (o_out_valid),
        .o_code   (o_field_code),
        .o_value  (o_field_value),
        .o_done   (o_frame_done)
    );

    a_done_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_done |-> o_field_code == FC_END)
        else $error("frame done on a result that is not the end mark");

    a_abort_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_abort_frame |=> !o_out_valid)
        else $error("abort produced a result");

    a_byte_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_field_code == FC_REQ || o_field_code == FC_BODY
                        || o_field_code == FC_TYPE)
        |-> o_field_value[VALUE_W-1:BYTE_W] == '0)
        else $error("single-byte field wider than a byte");

    a_len_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_field_code == FC_LEN |-> o_field_value[VALUE_W-1:LEN_W] == '0)
        else $error("body length wider than 32 bits");

endmodule

// ----- rtl/dfd_core.sv -----
// field phase tracking, big-endian assembly and result decode per byte
module dfd_core
    import dfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_abort_frame,
    output t_result           o_result
);

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [VALUE_W-1:0] r_acc, n_acc;
    logic [LEN_W-1:0]   r_remain, n_remain;

    logic [PHASE_W-1:0] cur_phase;
    logic [CNT_W-1:0]   cur_cnt, cnt_inc;
    logic [VALUE_W-1:0] cur_acc, acc_shift;
    logic [LEN_W-1:0]   remain_dec;
    t_result            res;

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_remain = r_remain;
        res      = '0;

        // meaningless phase codes restart at the start mark
        if (r_phase > PH_END) begin
            cur_phase = PH_START;
            cur_cnt   = '0;
            cur_acc   = '0;
        end else begin
            cur_phase = r_phase;
            cur_cnt   = r_cnt;
            cur_acc   = r_acc;
        end
        cnt_inc    = cur_cnt + 7'd1;
        acc_shift  = {cur_acc[VALUE_W-BYTE_W-1:0], i_data_byte};
        remain_dec = r_remain - 32'd1;

        if (i_abort_frame) begin
            n_phase  = PH_START;
            n_cnt    = '0;
            n_acc    = '0;
            n_remain = '0;
        end else if (cur_phase == PH_REQ) begin
            res.valid = 1'b1;
            res.code  = FC_REQ;
            res.value = {{(VALUE_W-BYTE_W){1'b0}}, i_data_byte};
            n_acc     = cur_acc;
            if (cnt_inc >= CNT_W'(REQ_ID_BYTES)) begin
                n_phase = PH_TIME;
                n_cnt   = '0;
            end else begin
                n_phase = cur_phase;
                n_cnt   = cnt_inc;
            end
        end else if (cur_phase == PH_BODY) begin
            res.valid = 1'b1;
            res.code  = FC_BODY;
            res.value = {{(VALUE_W-BYTE_W){1'b0}}, i_data_byte};
            n_cnt     = cur_cnt;
            n_acc     = cur_acc;
            n_remain  = remain_dec;
            n_phase   = (remain_dec == '0) ? PH_END : PH_BODY;
        end else if (cnt_inc < scalar_bytes(cur_phase)) begin
            n_phase = cur_phase;
            n_cnt   = cnt_inc;
            n_acc   = acc_shift;
        end else begin
            n_cnt     = '0;
            n_acc     = '0;
            res.value = acc_shift;
            unique case (cur_phase)
                PH_START: begin
                    n_phase   = PH_TYPE;
                    res.valid = 1'b1;
                    res.code  = FC_START;
                end
                PH_TYPE: begin
                    n_phase   = PH_TERM;
                    res.valid = 1'b1;
                    res.code  = FC_TYPE;
                end
                PH_TERM: begin
                    n_phase   = PH_REQ;
                    res.valid = 1'b1;
                    res.code  = FC_TERM;
                end
                PH_TIME: begin
                    n_phase   = PH_LEN;
                    res.valid = 1'b1;
                    res.code  = FC_TIME;
                end
                PH_LEN: begin
                    n_phase   = PH_PREFIX;
                    n_remain  = acc_shift[LEN_W-1:0];
                    res.valid = 1'b1;
                    res.code  = FC_LEN;
                    res.value = {{(VALUE_W-LEN_W){1'b0}}, acc_shift[LEN_W-1:0]};
                end
                PH_PREFIX: begin
                    n_phase = (r_remain != '0) ? PH_BODY : PH_END;
                end
                default: begin
                    n_phase   = PH_START;
                    res.valid = 1'b1;
                    res.code  = FC_END;
                    res.done  = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_cnt    <= '0;
            r_acc    <= '0;
            r_remain <= '0;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_acc    <= n_acc;
            r_remain <= n_remain;
        end
    end

    assign o_result = res;

endmodule

// ----- rtl/dfd_out_reg.sv -----
// result register with valid/ready toward the consumer
module dfd_out_reg
    import dfd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  t_result            i_result,
    input  logic               i_ready,
    output logic               o_free,
    output logic               o_valid,
    output logic [CODE_W-1:0]  o_code,
    output logic [VALUE_W-1:0] o_value,
    output logic               o_done
);

    logic               r_valid;
    logic [CODE_W-1:0]  r_code;
    logic [VALUE_W-1:0] r_value;
    logic               r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_result.valid;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_result.valid) begin
            r_code  <= i_result.code;
            r_value <= i_result.value;
            r_done  <= i_result.done;
        end
    end

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_code  = r_code;
    assign o_value = r_value;
    assign o_done  = r_done;

endmodule

// ----- tb/tb_top.sv -----
// testbench of the datagram field deframer: random framed byte streams checked against a predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dfd_pkg::*;

    localparam int ITEMS       = 1100;
    localparam int QUIET_LEFT  = 150;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN       = 20;
    localparam int LIMIT       = 200000;
    localparam int HEAD_BYTES  = 95;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              abort;
    } t_stream_byte;

    typedef struct {
        logic [CODE_W-1:0]  code;
        logic [VALUE_W-1:0] value;
        logic               done;
    } t_field;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [BYTE_W-1:0]  i_data_byte = '0;
    logic               i_abort_frame = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [CODE_W-1:0]  o_field_code;
    logic [VALUE_W-1:0] o_field_value;
    logic               o_frame_done;

    t_stream_byte pend_q[$];
    t_field       field_q[$];
    int           total_items = 0;
    int           n_fed = 0;
    int           n_bad = 0;
    int           cycle_cnt = 0;
    int           gap_left = 0;
    int           stall_left = 0;
    int           hold_left = 0;
    logic         hold_done = 1'b0;
    logic         quiet = 1'b0;

    logic [PHASE_W-1:0] ph;
    logic [CNT_W-1:0]   cnt;
    logic [VALUE_W-1:0] acc;
    logic [LEN_W-1:0]   body_len;
    logic [LEN_W-1:0]   body_rem;

    datagram_field_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_abort_frame (i_abort_frame),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_field_code  (o_field_code),
        .o_field_value (o_field_value),
        .o_frame_done  (o_frame_done)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [CNT_W-1:0] field_len(input logic [PHASE_W-1:0] p);
        case (p)
            PH_TYPE:          return 7'd1;
            PH_TERM, PH_TIME: return 7'd8;
            PH_LEN, PH_PREFIX: return 7'd4;
            default:          return 7'd2;
        endcase
    endfunction

    function automatic void clear_deframer();
        ph       = PH_START;
        cnt      = '0;
        acc      = '0;
        body_len = '0;
        body_rem = '0;
    endfunction

    function automatic void add_field(input logic [CODE_W-1:0] c, input logic [VALUE_W-1:0] v,
                                      input logic d);
        t_field f;
        f.code  = c;
        f.value = v;
        f.done  = d;
        field_q.push_back(f);
    endfunction

    function automatic void deframe_byte(input logic [BYTE_W-1:0] b, input logic ab);
        logic [VALUE_W-1:0] val;
        if (ab) begin
            clear_deframer();
            return;
        end
        if (ph > PH_END) begin
            ph  = PH_START;
            cnt = '0;
            acc = '0;
        end
        if (ph == PH_REQ) begin
            cnt = cnt + 7'd1;
            if (cnt >= CNT_W'(REQ_ID_BYTES)) begin
                ph  = PH_TIME;
                cnt = '0;
            end
            add_field(FC_REQ, VALUE_W'(b), 1'b0);
            return;
        end
        if (ph == PH_BODY) begin
            body_rem = body_rem - 32'd1;
            if (body_rem == '0)
                ph = PH_END;
            add_field(FC_BODY, VALUE_W'(b), 1'b0);
            return;
        end
        acc = {acc[VALUE_W-BYTE_W-1:0], b};
        cnt = cnt + 7'd1;
        if (cnt < field_len(ph))
            return;
        val = acc;
        acc = '0;
        cnt = '0;
        case (ph)
            PH_START: begin
                ph = PH_TYPE;
                add_field(FC_START, val, 1'b0);
            end
            PH_TYPE: begin
                ph = PH_TERM;
                add_field(FC_TYPE, val, 1'b0);
            end
            PH_TERM: begin
                ph = PH_REQ;
                add_field(FC_TERM, val, 1'b0);
            end
            PH_TIME: begin
                ph = PH_LEN;
                add_field(FC_TIME, val, 1'b0);
            end
            PH_LEN: begin
                body_len = val[LEN_W-1:0];
                body_rem = body_len;
                ph       = PH_PREFIX;
                add_field(FC_LEN, VALUE_W'(val[LEN_W-1:0]), 1'b0);
            end
            PH_PREFIX: begin
                ph = (body_rem != '0) ? PH_BODY : PH_END;
            end
            default: begin
                ph = PH_START;
                add_field(FC_END, val, 1'b1);
            end
        endcase
    endfunction

    task automatic push_item(input logic [BYTE_W-1:0] b, input logic ab);
        t_stream_byte s;
        s.data  = b;
        s.abort = ab;
        pend_q.push_back(s);
    endtask

    // cut < 0 sends the whole frame, else cut bytes followed by an abort
    task automatic gen_frame(input logic [LEN_W-1:0] blen, input int cut);
        logic [BYTE_W-1:0] bq[$];
        int                nbody;
        int                n;
        nbody = (blen > 64) ? 64 : int'(blen);
        for (int i = 0; i < 11 + REQ_ID_BYTES + 8; i++)
            bq.push_back(BYTE_W'($urandom));
        for (int i = 3; i >= 0; i--)
            bq.push_back(blen[i*8 +: 8]);
        for (int i = 0; i < 4 + nbody + 2; i++)
            bq.push_back(BYTE_W'($urandom));
        n = (cut < 0 || cut > bq.size()) ? bq.size() : cut;
        for (int i = 0; i < n; i++)
            push_item(bq[i], 1'b0);
        if (cut >= 0)
            push_item(BYTE_W'($urandom), 1'b1);
    endtask

    initial begin
        int k;
        int n;
        clear_deframer();
        push_item(8'hff, 1'b1);
        push_item(8'hff, 1'b0);
        push_item(8'hff, 1'b0);
        push_item(8'h00, 1'b0);
        for (int i = 0; i < 8; i++)
            push_item(8'hff, 1'b0);
        push_item(8'h80, 1'b0);
        push_item(8'h7f, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'h00, 1'b1);
        push_item(8'h00, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'hff, 1'b0);
        push_item(8'h5a, 1'b1);
        k = 0;
        while (pend_q.size() < ITEMS) begin
            if (k == 0)
                gen_frame('0, -1);
            else if (k == 1)
                gen_frame(32'd1, -1);
            else if (k == 2)
                gen_frame(32'hffff_ffff, HEAD_BYTES + $urandom_range(1, 8));
            else begin
                case ($urandom_range(0, 9))
                    6: gen_frame($urandom_range(25, 64), -1);
                    7: gen_frame($urandom, HEAD_BYTES + $urandom_range(0, 10));
                    8: gen_frame($urandom_range(0, 24), $urandom_range(0, HEAD_BYTES - 1));
                    9: begin
                        n = $urandom_range(1, 6);
                        for (int i = 0; i < n; i++)
                            push_item(BYTE_W'($urandom), $urandom_range(0, 3) == 0);
                        push_item(BYTE_W'($urandom), 1'b1);
                    end
                    default: gen_frame($urandom_range(0, 24), -1);
                endcase
            end
            k++;
        end
        total_items = pend_q.size();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (n_fed < total_items || field_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (n_bad == 0)
            $display("datagram_field_deframer: match");
        else
            $display("datagram_field_deframer: mismatch");
        $finish;
    end

    // driver
    always @(posedge i_clk) begin
        logic         nxt_valid;
        t_stream_byte s;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left   <= 0;
        end else begin
            nxt_valid = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                deframe_byte(i_data_byte, i_abort_frame);
                n_fed <= n_fed + 1;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left != 0)
                    gap_left <= gap_left - 1;
                else if (pend_q.size() != 0) begin
                    s = pend_q.pop_front();
                    i_data_byte   <= s.data;
                    i_abort_frame <= s.abort;
                    nxt_valid = 1'b1;
                    if (!quiet && $urandom_range(0, 5) == 0)
                        gap_left <= $urandom_range(1, 13);
                end
            end
            i_in_valid <= nxt_valid;
            quiet      <= (pend_q.size() < QUIET_LEFT);
        end
    end

    // long receiver hold-off so the block backs up into the input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_fed >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= 0;
        end else if (hold_left != 0) begin
            i_out_ready <= 1'b0;
        end else if (quiet) begin
            i_out_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left  <= $urandom_range(0, 12);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_field f;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (field_q.size() == 0) begin
                $display("%0t: unexpected item: expected none, actual code %0d value %h done %b",
                         $time, o_field_code, o_field_value, o_frame_done);
                n_bad++;
            end else begin
                f = field_q.pop_front();
                if (o_field_code !== f.code) begin
                    $display("%0t: field_code expected %0d actual %0d",
                             $time, f.code, o_field_code);
                    n_bad++;
                end
                if (o_field_value !== f.value) begin
                    $display("%0t: field_value expected %h actual %h",
                             $time, f.value, o_field_value);
                    n_bad++;
                end
                if (o_frame_done !== f.done) begin
                    $display("%0t: frame_done expected %b actual %b",
                             $time, f.done, o_frame_done);
                    n_bad++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("datagram_field_deframer: mismatch");
            $finish;
        end
    end

endmodule
